// File: design/axis_velocity_ramp_unit_assert.svh
// Assertion macros used by the velocity ramp top-level design file.
`ifndef AXIS_VELOCITY_RAMP_UNIT_ASSERT_SVH
`define AXIS_VELOCITY_RAMP_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define AVR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define AVR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/avr_pkg.sv
// Shared types, constants and microcode store of the velocity ramp unit.
package avr_pkg;

    localparam int NUM_AXES   = 3;
    localparam int AXIS_W     = 2;
    localparam int SPEED_W    = 32;
    localparam int ACC_W      = 31;
    localparam int MARGIN_W   = 16;
    localparam int DIR_W      = 16;
    localparam int DT_W       = 16;
    localparam int DT_FRAC    = 16;
    localparam int DIR_FRAC   = 14;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Shared multiplier: signed 48 x signed 17
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = DT_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // a*dt, a*dt*dt/2 and dir*a*dt term widths
    localparam int AD_W     = ACC_W + DT_W;
    localparam int T2_SHIFT = 2 * DT_FRAC + 1;
    localparam int T2_W     = ACC_W + 2 * DT_W - T2_SHIFT;
    localparam int DV_SHIFT = DT_FRAC + DIR_FRAC;
    localparam int DV_W     = 33;

    localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_X     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Y     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Z     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED_X = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED_Y = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED_Z = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN      = 8'd6;

    // Microprogram step addresses
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_MUL_ADT   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_ADDT  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_MUL_ADDIR = 3'd2;
    localparam logic [STEP_W-1:0] STEP_MUL_VDT   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_WRITE     = 3'd4;
    localparam logic [STEP_W-1:0] STEP_OUT       = 3'd5;

    typedef enum logic [1:0] {
        OPA_ACCEL,
        OPA_PROD,
        OPA_AD,
        OPA_SPEED
    } t_opa;

    typedef enum logic {
        OPB_DT,
        OPB_DIR
    } t_opb;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_AXIS,
        JMP_OUT
    } t_jmp;

    // One control word
    typedef struct packed {
        t_opa              opa;
        t_opb              opb;
        logic              ld_ad;
        logic              ld_t2;
        logic              ld_dv;
        logic              wr_axis;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
    } t_uop;

    // Sequencer to datapath controls
    typedef struct packed {
        logic              capture;
        logic              mul_en;
        t_opa              opa;
        t_opb              opb;
        logic              ld_ad;
        logic              ld_t2;
        logic              ld_dv;
        logic              wr_axis;
        logic [AXIS_W-1:0] axis;
    } t_dp_ctrl;

    function automatic t_uop mk_uop(input t_opa opa, input t_opb opb, input logic ld_ad,
                                    input logic ld_t2, input logic ld_dv,
                                    input logic wr_axis, input t_jmp jmp,
                                    input logic [STEP_W-1:0] target);
        t_uop u;
        u.opa     = opa;
        u.opb     = opb;
        u.ld_ad   = ld_ad;
        u.ld_t2   = ld_t2;
        u.ld_dv   = ld_dv;
        u.wr_axis = wr_axis;
        u.jmp     = jmp;
        u.target  = target;
        return u;
    endfunction

    // Control store: five steps per axis, looped three times, then publish
    function automatic t_uop avr_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            STEP_MUL_ADT:   u = mk_uop(OPA_ACCEL, OPB_DT,  1'b0, 1'b0, 1'b0, 1'b0,
                                       JMP_NEXT, STEP_MUL_ADT);
            STEP_MUL_ADDT:  u = mk_uop(OPA_PROD,  OPB_DT,  1'b1, 1'b0, 1'b0, 1'b0,
                                       JMP_NEXT, STEP_MUL_ADT);
            STEP_MUL_ADDIR: u = mk_uop(OPA_AD,    OPB_DIR, 1'b0, 1'b1, 1'b0, 1'b0,
                                       JMP_NEXT, STEP_MUL_ADT);
            STEP_MUL_VDT:   u = mk_uop(OPA_SPEED, OPB_DT,  1'b0, 1'b0, 1'b1, 1'b0,
                                       JMP_NEXT, STEP_MUL_ADT);
            STEP_WRITE:     u = mk_uop(OPA_ACCEL, OPB_DT,  1'b0, 1'b0, 1'b0, 1'b1,
                                       JMP_AXIS, STEP_MUL_ADT);
            default:        u = mk_uop(OPA_ACCEL, OPB_DT,  1'b0, 1'b0, 1'b0, 1'b0,
                                       JMP_OUT, STEP_MUL_ADT);
        endcase
        return u;
    endfunction

endpackage

// File: design/axis_velocity_ramp_unit.sv
// Each request runs five microcode steps per axis through the single shared 48x17
// multiplier, for each of the three axes in turn, then one publish step.
// The next request is taken during the publish step once the output slot frees.
// Reset (synchronous, active low) clears axis speeds, registers, sequencer, valid.
`include "axis_velocity_ramp_unit_assert.svh"

module axis_velocity_ramp_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Configuration writes
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [avr_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [avr_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    // Request channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [avr_pkg::DIR_W-1:0]        i_dir_x,
    input  logic signed [avr_pkg::DIR_W-1:0]        i_dir_y,
    input  logic signed [avr_pkg::DIR_W-1:0]        i_dir_z,
    input  logic [avr_pkg::DT_W-1:0]                i_time_step,
    // Result channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [avr_pkg::SPEED_W-1:0]      o_disp_x,
    output logic signed [avr_pkg::SPEED_W-1:0]      o_disp_y,
    output logic signed [avr_pkg::SPEED_W-1:0]      o_disp_z,
    output logic                                    o_moved,
    output logic signed [avr_pkg::SPEED_W-1:0]      o_speed_x,
    output logic signed [avr_pkg::SPEED_W-1:0]      o_speed_y,
    output logic signed [avr_pkg::SPEED_W-1:0]      o_speed_z
);
    import avr_pkg::*;

    logic [NUM_AXES-1:0][ACC_W-1:0] r_accel;
    logic [NUM_AXES-1:0][ACC_W-1:0] r_top;
    logic [MARGIN_W-1:0]            r_margin;

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_step, n_step;
    logic [AXIS_W-1:0] r_axis, n_axis;

    logic                             r_o_valid;
    logic                             r_o_moved;
    logic [NUM_AXES-1:0][SPEED_W-1:0] r_o_disp;
    logic [NUM_AXES-1:0][SPEED_W-1:0] r_o_speed;

    t_uop     uop;
    t_dp_ctrl dp_ctrl;
    logic     slot_free;
    logic     publish;
    logic     in_acc;

    logic [NUM_AXES-1:0][DIR_W-1:0]   dir_in;
    logic [NUM_AXES-1:0][SPEED_W-1:0] dp_speed;
    logic [NUM_AXES-1:0][SPEED_W-1:0] dp_disp;
    logic                             dp_moved;

    // Configuration registers; no handshake while in reset
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel  <= '0;
            r_top    <= '0;
            r_margin <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ACCEL_X:     r_accel[0] <= i_cfg_data[ACC_W-1:0];
                REG_ACCEL_Y:     r_accel[1] <= i_cfg_data[ACC_W-1:0];
                REG_ACCEL_Z:     r_accel[2] <= i_cfg_data[ACC_W-1:0];
                REG_TOP_SPEED_X: r_top[0]   <= i_cfg_data[ACC_W-1:0];
                REG_TOP_SPEED_Y: r_top[1]   <= i_cfg_data[ACC_W-1:0];
                REG_TOP_SPEED_Z: r_top[2]   <= i_cfg_data[ACC_W-1:0];
                REG_MARGIN:      r_margin   <= i_cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Microcode fetch and handshake
    assign uop        = avr_rom(r_step);
    assign slot_free  = !r_o_valid || i_out_ready;
    assign publish    = r_busy && (uop.jmp == JMP_OUT) && slot_free;
    assign o_in_ready = i_rst_n && (!r_busy || publish);
    assign in_acc     = i_in_valid && o_in_ready;

    // Step counter and axis loop
    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_axis = r_axis;
        if (in_acc) begin
            n_busy = 1'b1;
            n_step = STEP_MUL_ADT;
            n_axis = '0;
        end else if (r_busy) begin
            case (uop.jmp)
                JMP_NEXT: n_step = r_step + STEP_W'(1);
                JMP_AXIS: begin
                    if (r_axis == AXIS_LAST) begin
                        n_axis = '0;
                        n_step = r_step + STEP_W'(1);
                    end else begin
                        n_axis = r_axis + AXIS_W'(1);
                        n_step = uop.target;
                    end
                end
                JMP_OUT: begin
                    if (publish) begin
                        n_busy = 1'b0;
                    end
                end
                default: n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_MUL_ADT;
            r_axis <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            r_axis <= n_axis;
        end
    end

    // Datapath controls
    always_comb begin
        dp_ctrl.capture = in_acc;
        dp_ctrl.mul_en  = r_busy;
        dp_ctrl.opa     = uop.opa;
        dp_ctrl.opb     = uop.opb;
        dp_ctrl.ld_ad   = r_busy && uop.ld_ad;
        dp_ctrl.ld_t2   = r_busy && uop.ld_t2;
        dp_ctrl.ld_dv   = r_busy && uop.ld_dv;
        dp_ctrl.wr_axis = r_busy && uop.wr_axis;
        dp_ctrl.axis    = r_axis;
    end

    assign dir_in = {i_dir_z, i_dir_y, i_dir_x};

    avr_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (dp_ctrl),
        .i_dir    (dir_in),
        .i_dt     (i_time_step),
        .i_accel  (r_accel),
        .i_top    (r_top),
        .i_margin (r_margin),
        .o_speed  (dp_speed),
        .o_disp   (dp_disp),
        .o_moved  (dp_moved)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (publish) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (publish) begin
            r_o_moved <= dp_moved;
            r_o_disp  <= dp_disp;
            r_o_speed <= dp_speed;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_moved     = r_o_moved;
    assign o_disp_x    = r_o_disp[0];
    assign o_disp_y    = r_o_disp[1];
    assign o_disp_z    = r_o_disp[2];
    assign o_speed_x   = r_o_speed[0];
    assign o_speed_y   = r_o_speed[1];
    assign o_speed_z   = r_o_speed[2];

    // Checks
    `AVR_ASSERT_SAME(a_still_no_disp, i_clk, i_rst_n, r_o_valid && !r_o_moved, r_o_disp == '0, "displacement without motion")
    `AVR_ASSERT_NEXT(a_overlap_publishes, i_clk, i_rst_n, in_acc && r_busy, r_o_valid, "request taken while busy without publishing")
    `AVR_ASSERT_SAME(a_axis_range, i_clk, i_rst_n, r_busy, r_axis <= AXIS_LAST, "axis counter out of range")
    `AVR_ASSERT_NEXT(a_last_axis_to_out, i_clk, i_rst_n, dp_ctrl.wr_axis && (r_axis == AXIS_LAST), r_busy && (r_step == STEP_OUT), "axis loop did not end in publish step")

endmodule

// File: design/avr_datapath.sv
// Datapath of the velocity ramp unit: shared multiplier, work registers, axis speeds.
module avr_datapath (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  avr_pkg::t_dp_ctrl                                    i_ctrl,
    input  logic [avr_pkg::NUM_AXES-1:0][avr_pkg::DIR_W-1:0]     i_dir,
    input  logic [avr_pkg::DT_W-1:0]                             i_dt,
    input  logic [avr_pkg::NUM_AXES-1:0][avr_pkg::ACC_W-1:0]     i_accel,
    input  logic [avr_pkg::NUM_AXES-1:0][avr_pkg::ACC_W-1:0]     i_top,
    input  logic [avr_pkg::MARGIN_W-1:0]                         i_margin,
    output logic [avr_pkg::NUM_AXES-1:0][avr_pkg::SPEED_W-1:0]   o_speed,
    output logic [avr_pkg::NUM_AXES-1:0][avr_pkg::SPEED_W-1:0]   o_disp,
    output logic                                                 o_moved
);
    import avr_pkg::*;

    logic [NUM_AXES-1:0][SPEED_W-1:0] r_speed;
    logic [NUM_AXES-1:0][SPEED_W-1:0] r_disp;
    logic [NUM_AXES-1:0][DIR_W-1:0]   r_dir;
    logic [DT_W-1:0]                  r_dt;
    logic                             r_moved;
    logic signed [PROD_W-1:0]         r_prod;
    logic [AD_W-1:0]                  r_ad;
    logic [T2_W-1:0]                  r_t2;
    logic signed [DV_W-1:0]           r_dv;

    logic [ACC_W-1:0]          cur_accel;
    logic [ACC_W-1:0]          cur_top;
    logic signed [SPEED_W-1:0] cur_speed;
    logic signed [DIR_W-1:0]   cur_dir;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    logic signed [SPEED_W-1:0] t1;
    logic signed [SPEED_W:0]   disp_sum;
    logic [SPEED_W-1:0]        disp_sat;
    logic [SPEED_W-1:0]        speed_mag;
    logic                      suppress;
    logic [SPEED_W-1:0]        disp_new;
    logic signed [SPEED_W+1:0] drv_sum;
    logic signed [SPEED_W+1:0] top_s;
    logic [SPEED_W-1:0]        drv_speed;
    logic [ACC_W-1:0]          dec_step;
    logic signed [SPEED_W:0]   dec_sum;
    logic [SPEED_W-1:0]        dec_speed;
    logic [SPEED_W-1:0]        speed_new;

    // Operands of the axis in work
    always_comb begin
        case (i_ctrl.axis)
            2'd0: begin
                cur_accel = i_accel[0];
                cur_top   = i_top[0];
                cur_speed = r_speed[0];
                cur_dir   = r_dir[0];
            end
            2'd1: begin
                cur_accel = i_accel[1];
                cur_top   = i_top[1];
                cur_speed = r_speed[1];
                cur_dir   = r_dir[1];
            end
            default: begin
                cur_accel = i_accel[2];
                cur_top   = i_top[2];
                cur_speed = r_speed[2];
                cur_dir   = r_dir[2];
            end
        endcase
    end

    // Shared multiplier operand select
    always_comb begin
        case (i_ctrl.opa)
            OPA_ACCEL: mul_a = {{(MUL_A_W-ACC_W){1'b0}}, cur_accel};
            OPA_PROD:  mul_a = r_prod[MUL_A_W-1:0];
            OPA_AD:    mul_a = {{(MUL_A_W-AD_W){1'b0}}, r_ad};
            OPA_SPEED: mul_a = {{(MUL_A_W-SPEED_W){cur_speed[SPEED_W-1]}}, cur_speed};
            default:   mul_a = '0;
        endcase
        case (i_ctrl.opb)
            OPB_DIR: mul_b = {cur_dir[DIR_W-1], cur_dir};
            default: mul_b = {1'b0, r_dt};
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Displacement: floor(v*dt) + a*dt*dt/2, saturated, suppressed near rest or when no axis moved
    assign t1        = r_prod[DT_FRAC +: SPEED_W];
    assign disp_sum  = $signed({t1[SPEED_W-1], t1})
                     + $signed({{(SPEED_W+1-T2_W){1'b0}}, r_t2});
    assign disp_sat  = (disp_sum[SPEED_W] != disp_sum[SPEED_W-1])
                     ? {disp_sum[SPEED_W], {(SPEED_W-1){~disp_sum[SPEED_W]}}}
                     : disp_sum[SPEED_W-1:0];
    assign speed_mag = cur_speed[SPEED_W-1] ? SPEED_W'(-cur_speed) : cur_speed;
    assign suppress  = (cur_dir == '0)
                     && (speed_mag <= {{(SPEED_W-MARGIN_W){1'b0}}, i_margin});
    assign disp_new  = (!r_moved || suppress) ? '0 : disp_sat;

    // Driven axis: add dir*a*dt, clamp to the top speed
    assign drv_sum = $signed({{2{cur_speed[SPEED_W-1]}}, cur_speed})
                   + $signed({r_dv[DV_W-1], r_dv});
    assign top_s   = $signed({3'b000, cur_top});

    always_comb begin
        if (drv_sum > top_s) begin
            drv_speed = SPEED_W'(top_s);
        end else if (drv_sum < -top_s) begin
            drv_speed = SPEED_W'(-top_s);
        end else begin
            drv_speed = drv_sum[SPEED_W-1:0];
        end
    end

    // Released axis: decay toward zero by a*dt, stop at zero
    assign dec_step = r_ad[DT_FRAC +: ACC_W];

    always_comb begin
        if (cur_speed > 0) begin
            dec_sum   = $signed({cur_speed[SPEED_W-1], cur_speed})
                      - $signed({2'b00, dec_step});
            dec_speed = dec_sum[SPEED_W] ? '0 : dec_sum[SPEED_W-1:0];
        end else begin
            dec_sum   = $signed({cur_speed[SPEED_W-1], cur_speed})
                      + $signed({2'b00, dec_step});
            dec_speed = (dec_sum > 0) ? '0 : dec_sum[SPEED_W-1:0];
        end
    end

    assign speed_new = (cur_dir != '0) ? drv_speed : dec_speed;

    // Request capture and work registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_dir   <= i_dir;
            r_dt    <= i_dt;
            r_moved <= (r_speed != '0);
        end
        if (i_ctrl.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_ctrl.ld_ad) begin
            r_ad <= r_prod[AD_W-1:0];
        end
        if (i_ctrl.ld_t2) begin
            r_t2 <= r_prod[T2_SHIFT +: T2_W];
        end
        if (i_ctrl.ld_dv) begin
            r_dv <= r_prod[DV_SHIFT +: DV_W];
        end
        if (i_ctrl.wr_axis) begin
            r_disp[i_ctrl.axis] <= disp_new;
        end
    end

    // Axis speed state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
        end else if (i_ctrl.wr_axis) begin
            r_speed[i_ctrl.axis] <= speed_new;
        end
    end

    assign o_speed = r_speed;
    assign o_disp  = r_disp;
    assign o_moved = r_moved;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the three-axis velocity ramp unit.
module tb;
    import avr_pkg::*;

    // Register indexes the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

    localparam int     TIME_FRAC   = 16;
    localparam int     DRIVE_FRAC  = 14;
    localparam longint DISP_MAX    = 64'sd2147483647;
    localparam longint DISP_MIN    = -64'sd2147483648;
    localparam int     HOLD_CYCLES = 400;
    localparam int     DRAIN_LIMIT = 10000;
    localparam int     SETTLE      = 40;
    localparam int     REPORT_MAX  = 10;
    localparam int     LIMIT_NS    = 1_000_000;

    typedef enum {
        PROFILE_RANDOM,
        PROFILE_MAX,
        PROFILE_ZERO
    } t_reg_profile;

    // One tick request and one motion result
    typedef struct packed {
        logic [NUM_AXES-1:0][DIR_W-1:0] dir;
        logic [DT_W-1:0]                dt;
    } t_tick;

    typedef struct packed {
        logic [NUM_AXES-1:0][SPEED_W-1:0] disp;
        logic                             moved;
        logic [NUM_AXES-1:0][SPEED_W-1:0] speed;
    } t_motion;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data  = '0;

    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    logic signed [DIR_W-1:0]       i_dir_x     = '0;
    logic signed [DIR_W-1:0]       i_dir_y     = '0;
    logic signed [DIR_W-1:0]       i_dir_z     = '0;
    logic [DT_W-1:0]               i_time_step = '0;

    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic signed [SPEED_W-1:0]     o_disp_x;
    logic signed [SPEED_W-1:0]     o_disp_y;
    logic signed [SPEED_W-1:0]     o_disp_z;
    logic                          o_moved;
    logic signed [SPEED_W-1:0]     o_speed_x;
    logic signed [SPEED_W-1:0]     o_speed_y;
    logic signed [SPEED_W-1:0]     o_speed_z;

    // Pending ticks and the motion results still owed by the block
    t_tick   tick_queue[$];
    t_motion motion_expect[$];

    // Shadow of the block's velocities and registers
    longint              axis_vel  [NUM_AXES];
    logic [ACC_W-1:0]    accel_mag [NUM_AXES];
    logic [ACC_W-1:0]    speed_cap [NUM_AXES];
    logic [MARGIN_W-1:0] stop_margin;

    string axis_tag [NUM_AXES] = '{"x", "y", "z"};

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    bit in_taken       = 1'b0;

    int fail_count     = 0;
    int tick_count     = 0;
    int moving_count   = 0;
    int clip_count     = 0;
    int settings_count = 0;

    axis_velocity_ramp_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_dir_x     (i_dir_x),
        .i_dir_y     (i_dir_y),
        .i_dir_z     (i_dir_z),
        .i_time_step (i_time_step),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_disp_x    (o_disp_x),
        .o_disp_y    (o_disp_y),
        .o_disp_z    (o_disp_z),
        .o_moved     (o_moved),
        .o_speed_x   (o_speed_x),
        .o_speed_y   (o_speed_y),
        .o_speed_z   (o_speed_z)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Register write as the block sees it; unknown indexes are dropped
    function automatic void shadow_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ACCEL_X:     accel_mag[0] = data[ACC_W-1:0];
            REG_ACCEL_Y:     accel_mag[1] = data[ACC_W-1:0];
            REG_ACCEL_Z:     accel_mag[2] = data[ACC_W-1:0];
            REG_TOP_SPEED_X: speed_cap[0] = data[ACC_W-1:0];
            REG_TOP_SPEED_Y: speed_cap[1] = data[ACC_W-1:0];
            REG_TOP_SPEED_Z: speed_cap[2] = data[ACC_W-1:0];
            REG_MARGIN:      stop_margin  = data[MARGIN_W-1:0];
            default: ;
        endcase
    endfunction

    // One tick of the ramp: displacement from the old speed, then the speed update
    function automatic t_motion ramp_tick(input t_tick t);
        t_motion r;
        longint  dt, d, v, a, top, mag, shift_v, shift_a, step, sum;
        logic    any_moving;
        r  = '0;
        dt = longint'(t.dt);
        any_moving = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (axis_vel[i] != 0) any_moving = 1'b1;
        end
        r.moved = any_moving;

        if (any_moving) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                v       = axis_vel[i];
                mag     = (v < 0) ? -v : v;
                shift_v = (v * dt) >>> TIME_FRAC;
                // a*dt*dt/2 stays below 2^63, so signed arithmetic is safe
                shift_a = (longint'(accel_mag[i]) * dt * dt) >>> (2 * TIME_FRAC + 1);
                if (t.dir[i] == '0 && mag <= longint'(stop_margin)) begin
                    sum = 0;
                end else begin
                    sum = shift_v + shift_a;
                    if (sum > DISP_MAX) sum = DISP_MAX;
                    else if (sum < DISP_MIN) sum = DISP_MIN;
                end
                r.disp[i] = sum[SPEED_W-1:0];
            end
        end

        for (int i = 0; i < NUM_AXES; i++) begin
            v = axis_vel[i];
            a = longint'(accel_mag[i]);
            d = longint'($signed(t.dir[i]));
            if (d != 0) begin
                top = longint'(speed_cap[i]);
                v   = v + ((d * a * dt) >>> (TIME_FRAC + DRIVE_FRAC));
                if (v > top) v = top;
                else if (v < -top) v = -top;
            end else begin
                step = (a * dt) >>> TIME_FRAC;
                if (v > 0) begin
                    v = v - step;
                    if (v < 0) v = 0;
                end else begin
                    v = v + step;
                    if (v > 0) v = 0;
                end
            end
            axis_vel[i]  = v;
            r.speed[i]   = v[SPEED_W-1:0];
        end
        return r;
    endfunction

    function automatic void log_failure(input string what, input t_motion want,
                                        input t_motion got);
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
            $display("[%0t] %s", $time, what);
            $display("    expected disp %0d %0d %0d moved %0d speed %0d %0d %0d",
                     $signed(want.disp[0]), $signed(want.disp[1]), $signed(want.disp[2]),
                     want.moved, $signed(want.speed[0]), $signed(want.speed[1]),
                     $signed(want.speed[2]));
            $display("    actual   disp %0d %0d %0d moved %0d speed %0d %0d %0d",
                     $signed(got.disp[0]), $signed(got.disp[1]), $signed(got.disp[2]),
                     got.moved, $signed(got.speed[0]), $signed(got.speed[1]),
                     $signed(got.speed[2]));
        end
    endfunction

    // Request driver: at each falling edge, once the last tick is taken, offer a new tick or idle
    always @(negedge i_clk) begin
        t_tick cur;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur = tick_queue.pop_front();
                i_in_valid  <= 1'b1;
                i_dir_x     <= cur.dir[0];
                i_dir_y     <= cur.dir[1];
                i_dir_z     <= cur.dir[2];
                i_time_step <= cur.dt;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a counted hold-off when asked
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: check results first, then predict the newly accepted tick
    always @(posedge i_clk) begin
        t_motion got, want;
        t_tick   seen;
        string   bad;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.disp  = {o_disp_z, o_disp_y, o_disp_x};
                got.moved = o_moved;
                got.speed = {o_speed_z, o_speed_y, o_speed_x};
                if (motion_expect.size() == 0) begin
                    log_failure("result with no tick outstanding", '0, got);
                end else begin
                    want = motion_expect.pop_front();
                    bad  = "";
                    for (int i = 0; i < NUM_AXES; i++) begin
                        if (got.disp[i] !== want.disp[i]) bad = {bad, " disp_", axis_tag[i]};
                        if (got.speed[i] !== want.speed[i]) bad = {bad, " speed_", axis_tag[i]};
                    end
                    if (got.moved !== want.moved) bad = {bad, " moved"};
                    if (bad != "") log_failure({"mismatch on", bad}, want, got);
                end
            end
            if (i_in_valid && o_in_ready) begin
                in_taken    = 1'b1;
                seen.dir    = {i_dir_z, i_dir_y, i_dir_x};
                seen.dt     = i_time_step;
                want        = ramp_tick(seen);
                tick_count++;
                if (want.moved) moving_count++;
                for (int i = 0; i < NUM_AXES; i++) begin
                    if (want.disp[i] == SPEED_W'(DISP_MAX)) begin
                        clip_count++;
                        break;
                    end
                end
                motion_expect.insert(motion_expect.size(), want);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_reg_write(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_tick(input int dx, input int dy, input int dz, input int dt);
        t_tick t;
        t.dir[0] = DIR_W'(dx);
        t.dir[1] = DIR_W'(dy);
        t.dir[2] = DIR_W'(dz);
        t.dt     = DT_W'(dt);
        tick_queue.insert(tick_queue.size(), t);
    endtask

    // Block idle: nothing queued, nothing offered, nothing owed
    task automatic wait_idle();
        while (tick_queue.size() != 0 || i_in_valid || motion_expect.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_profile(input t_reg_profile profile);
        logic [CFG_DATA_W-1:0] cap, acc, margin;
        for (int i = 0; i < NUM_AXES; i++) begin
            case (profile)
                PROFILE_MAX: begin
                    cap = '1;
                    acc = '1;
                end
                PROFILE_ZERO: begin
                    cap = '0;
                    acc = '0;
                end
                default: begin
                    // ramps of a few to a few dozen ticks; top bit is junk
                    cap = $urandom >> $urandom_range(1, 24);
                    acc = (cap >> $urandom_range(0, 6)) | ($urandom & 32'h8000_0000);
                    cap = cap | ($urandom & 32'h8000_0000);
                end
            endcase
            write_reg(REG_ACCEL_X + CFG_IDX_W'(i), acc);
            write_reg(REG_TOP_SPEED_X + CFG_IDX_W'(i), cap);
        end
        case (profile)
            PROFILE_MAX:  margin = '1;
            PROFILE_ZERO: margin = '0;
            default:      margin = $urandom;
        endcase
        write_reg(REG_MARGIN, margin);
        settings_count++;
    endtask

    function automatic int pick_dir();
        int r;
        r = $urandom_range(99);
        if (r < 35) return 0;
        if (r < 75) return $urandom_range(0, 32768) - 16384;
        if (r < 85) return ($urandom_range(1) != 0) ? 16384 : -16384;
        if (r < 92) return $urandom_range(0, 65535);
        return ($urandom_range(1) != 0) ? $urandom_range(1, 64) : -$urandom_range(1, 64);
    endfunction

    function automatic int pick_dt();
        int r;
        r = $urandom_range(99);
        if (r < 5) return 0;
        if (r < 10) return 65535;
        if (r < 40) return $urandom_range(0, 4095);
        return $urandom_range(0, 65535);
    endfunction

    // Held drive patterns so speeds ramp to their caps and decay back
    task automatic queue_gestures(input int count);
        int dx, dy, dz, run;
        while (count > 0) begin
            dx  = pick_dir();
            dy  = pick_dir();
            dz  = pick_dir();
            run = $urandom_range(1, 10);
            for (int k = 0; k < run && count > 0; k++) begin
                if ($urandom_range(99) < 10)
                    add_tick($urandom, $urandom, $urandom, $urandom);
                else
                    add_tick(dx, dy, dz, pick_dt());
                count--;
            end
        end
    endtask

    task automatic run_phase(input int count, input int send_pct, input int recv_pct,
                             input bit long_hold);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_gestures(count);
        if (long_hold) begin
            @(posedge i_clk);
            hold_left = HOLD_CYCLES;
        end
        wait_idle();
    endtask

    // Watchdog
    initial begin
        #(LIMIT_NS);
        $display("Timed out with %0d ticks checked", tick_count);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int waited;
        for (int i = 0; i < NUM_AXES; i++) begin
            axis_vel[i]  = 0;
            accel_mag[i] = '0;
            speed_cap[i] = '0;
        end
        stop_margin = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: full drive cannot move anything
        add_tick(16384, -16384, 16384, 65535);
        wait_idle();
        settings_count++;

        write_reg(REG_ACCEL_X, 32'h7FFF_FFFF);
        write_reg(REG_ACCEL_Y, 32'h0000_0100);
        write_reg(REG_ACCEL_Z, 32'hFFFF_FFFF);
        write_reg(REG_TOP_SPEED_X, 32'h7FFF_FFFF);
        write_reg(REG_TOP_SPEED_Y, 32'd1000);
        write_reg(REG_TOP_SPEED_Z, 32'h4000_0000);
        write_reg(REG_MARGIN, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED_LO, $urandom);
        write_reg(REG_UNUSED_HI, $urandom);
        settings_count++;

        // Directed: standstill, full ramps, clipping, release near zero, odd drives
        add_tick(0, 0, 0, 16'h8000);
        add_tick(16384, 16384, -16384, 65535);
        add_tick(16384, 16384, -16384, 65535);
        add_tick(0, 0, 0, 100);
        add_tick(0, 0, 0, 0);
        add_tick(16'h7FFF, -32768, 1, 1);
        add_tick(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        add_tick(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        add_tick(-16384, 0, 16384, 65535);
        add_tick(0, 0, 0, 65535);
        add_tick(1, -1, 0, 65535);
        add_tick(0, 0, 0, 65535);
        add_tick(0, 0, 0, 65535);
        add_tick(0, 0, 0, 65535);
        add_tick(-16384, -16384, -16384, 65535);
        add_tick(0, 16384, 0, 0);
        add_tick(0, 0, 0, 32768);
        wait_idle();

        load_profile(PROFILE_RANDOM);
        run_phase(380, 0, 0, 1'b0);
        load_profile(PROFILE_RANDOM);
        run_phase(380, 87, 0, 1'b0);
        load_profile(PROFILE_MAX);
        run_phase(380, 0, 87, 1'b1);
        load_profile(PROFILE_RANDOM);
        run_phase(380, 10, 10, 1'b0);

        // Last phase: all registers at zero, drain bounded
        load_profile(PROFILE_ZERO);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_gestures(60);
        waited = 0;
        while ((tick_queue.size() != 0 || i_in_valid || motion_expect.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (motion_expect.size() != 0) begin
            fail_count++;
            $display("%0d results never arrived", motion_expect.size());
        end

        $display("Checked %0d ticks over %0d register settings: %0d in motion, %0d clipped",
                 tick_count, settings_count, moving_count, clip_count);
        $display("Idle mixes: none, sender-heavy, receiver-heavy with a %0d-cycle hold-off, light",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
